// ===== rtl/core/ffra_pkg.sv =====
package ffra_pkg;

    // Page size limit; field widths are sized for it
    localparam int MAX_PAGE_BLOCKS = 1024;

    // Request codes
    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_FREE   = 2'd1;
    localparam logic [1:0] OP_FIND   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    // Datapath commands issued by the controller
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_INIT,
        CMD_SCAN_START,
        CMD_SCAN_STEP,
        CMD_SHIFT_UP,
        CMD_SHIFT_DOWN,
        CMD_ALLOC_SPLIT,
        CMD_ALLOC_EXACT,
        CMD_FREE_MARK,
        CMD_MERGE_NEXT,
        CMD_MERGE_PREV,
        CMD_READ,
        CMD_RESULT
    } cmd_t;

    // Status returned from the datapath
    typedef struct packed {
        logic scan_hit;
        logic scan_end;
        logic shift_done;
        logic split_needed;
        logic table_full;
        logic next_free;
        logic prev_free;
        logic index_bad;
        logic req_zero;
    } dp_status_t;

endpackage

// ===== rtl/core/ffra_datapath.sv =====
module ffra_datapath
    import ffra_pkg::*;
#(
    parameter int MAX_RANGES      = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    input  logic        load_req,
    input  logic [1:0]  in_op,
    input  logic [10:0] in_req,
    input  logic [9:0]  in_blk,
    input  logic        cfg_we,
    input  logic [10:0] cfg_data,
    output dp_status_t  status,
    output logic [9:0]  res_start,
    output logic [10:0] res_length,
    output logic        res_free
);

    localparam int IW = $clog2(MAX_RANGES);
    localparam int CW = $clog2(MAX_RANGES + 1);

    // Range table
    logic [9:0]  start_mem [MAX_RANGES];
    logic [10:0] len_mem   [MAX_RANGES];
    logic        free_mem  [MAX_RANGES];

    logic [10:0]   page_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg;   // scan index / target entry
    logic [CW-1:0] sh_reg;    // shift pointer
    logic [1:0]    op_reg;
    logic [10:0]   req_reg;
    logic [9:0]    blk_reg;
    logic [9:0]    cur_start_reg;
    logic [10:0]   cur_len_reg;
    logic          cur_free_reg;
    logic          shift_done_reg;

    // Neighbors of the entry being freed
    logic          nxt_free_reg;
    logic [10:0]   nxt_len_reg;
    logic          prv_free_reg;
    logic [9:0]    prv_start_reg;
    logic [10:0]   prv_len_reg;

    // Result held for the output channel
    logic [9:0]    out_start_reg;
    logic [10:0]   out_len_reg;
    logic          out_free_reg;

    logic [10:0] page_clamped;
    logic [IW-1:0] ia, ia1, ia_m1;
    logic [11:0] end_sum;
    logic        hit;

    // Register clamp
    always_comb
    begin
        if (cfg_data == 11'd0)
            page_clamped = 11'd1;
        else if (32'(cfg_data) > MAX_PAGE_BLOCKS)
            page_clamped = 11'(MAX_PAGE_BLOCKS);
        else
            page_clamped = cfg_data;
    end

    assign ia    = idx_reg[IW-1:0];
    assign ia1   = IW'(idx_reg + CW'(1));
    assign ia_m1 = IW'(idx_reg - CW'(1));
    assign end_sum = {2'b00, cur_start_reg} + {1'b0, cur_len_reg};

    // Scan match on the entry just read
    always_comb
    begin
        if (op_reg == OP_ALLOC)
            hit = cur_free_reg && (cur_len_reg >= req_reg);
        else
            hit = ({2'b00, blk_reg} >= {2'b00, cur_start_reg}) &&
                  ({2'b00, blk_reg} < end_sum);
    end

    assign status.scan_hit     = hit && (idx_reg < count_reg);
    assign status.scan_end     = idx_reg >= count_reg;
    assign status.shift_done   = shift_done_reg;
    assign status.split_needed = cur_len_reg > req_reg;
    assign status.table_full   = count_reg >= CW'(MAX_RANGES);
    assign status.next_free    = (idx_reg + CW'(1) < count_reg) && nxt_free_reg;
    assign status.prev_free    = (idx_reg != '0) && prv_free_reg;
    assign status.index_bad    = {1'b0, blk_reg} >= page_reg;
    assign status.req_zero     = req_reg == 11'd0;

    assign res_start  = out_start_reg;
    assign res_length = out_len_reg;
    assign res_free   = out_free_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_reg  <= 11'(MAX_PAGE_BLOCKS > 1024 ? 1024 : MAX_PAGE_BLOCKS);
            count_reg <= CW'(1);
        end
        else if (cfg_we)
        begin
            page_reg  <= page_clamped;
            count_reg <= CW'(1);
        end
        else
        begin
            unique case (cmd)
                CMD_ALLOC_SPLIT: count_reg <= count_reg + CW'(1);
                CMD_MERGE_NEXT,
                CMD_MERGE_PREV:  count_reg <= count_reg - CW'(1);
                default:         count_reg <= count_reg;
            endcase
        end
    end

    // Table and working registers; a shift moves one entry per cycle
    always_ff @(posedge clk)
    begin
        if (load_req)
        begin
            op_reg  <= in_op;
            req_reg <= in_req;
            blk_reg <= in_blk;
        end
        if (cfg_we || cmd == CMD_INIT)
        begin
            start_mem[0] <= 10'd0;
            len_mem[0]   <= cfg_we ? page_clamped : page_reg;
            free_mem[0]  <= 1'b1;
        end
        else
        begin
            unique case (cmd)
                CMD_SCAN_START:
                begin
                    idx_reg       <= '0;
                    cur_start_reg <= start_mem[0];
                    cur_len_reg   <= len_mem[0];
                    cur_free_reg  <= free_mem[0];
                    sh_reg        <= count_reg;
                    shift_done_reg <= 1'b0;
                end
                CMD_SCAN_STEP:
                begin
                    idx_reg       <= idx_reg + CW'(1);
                    cur_start_reg <= start_mem[ia1];
                    cur_len_reg   <= len_mem[ia1];
                    cur_free_reg  <= free_mem[ia1];
                end
                CMD_SHIFT_UP:
                begin
                    // open a hole at idx+1: move entry sh-1 to sh
                    if (sh_reg > idx_reg + CW'(1))
                    begin
                        start_mem[IW'(sh_reg)] <= start_mem[IW'(sh_reg - CW'(1))];
                        len_mem[IW'(sh_reg)]   <= len_mem[IW'(sh_reg - CW'(1))];
                        free_mem[IW'(sh_reg)]  <= free_mem[IW'(sh_reg - CW'(1))];
                        sh_reg <= sh_reg - CW'(1);
                        shift_done_reg <= (sh_reg - CW'(1)) <= idx_reg + CW'(1);
                    end
                    else
                        shift_done_reg <= 1'b1;
                end
                CMD_SHIFT_DOWN:
                begin
                    // close the hole at sh: move entry sh+1 to sh (count already reduced)
                    if (sh_reg < count_reg)
                    begin
                        start_mem[IW'(sh_reg)] <= start_mem[IW'(sh_reg + CW'(1))];
                        len_mem[IW'(sh_reg)]   <= len_mem[IW'(sh_reg + CW'(1))];
                        free_mem[IW'(sh_reg)]  <= free_mem[IW'(sh_reg + CW'(1))];
                        sh_reg <= sh_reg + CW'(1);
                        shift_done_reg <= sh_reg + CW'(1) >= count_reg;
                    end
                    else
                        shift_done_reg <= 1'b1;
                end
                CMD_ALLOC_SPLIT:
                begin
                    start_mem[ia1] <= 10'(end_sum - {1'b0, cur_len_reg} + {1'b0, req_reg});
                    len_mem[ia1]   <= cur_len_reg - req_reg;
                    free_mem[ia1]  <= 1'b1;
                    len_mem[ia]    <= req_reg;
                    free_mem[ia]   <= 1'b0;
                    cur_len_reg    <= req_reg;
                    cur_free_reg   <= 1'b0;
                end
                CMD_ALLOC_EXACT:
                begin
                    free_mem[ia] <= 1'b0;
                    cur_free_reg <= 1'b0;
                end
                CMD_FREE_MARK:
                begin
                    free_mem[ia]   <= 1'b1;
                    cur_free_reg   <= 1'b1;
                    sh_reg         <= idx_reg + CW'(1);
                    shift_done_reg <= 1'b0;
                    nxt_free_reg   <= free_mem[ia1];
                    nxt_len_reg    <= len_mem[ia1];
                    prv_free_reg   <= free_mem[ia_m1];
                    prv_start_reg  <= start_mem[ia_m1];
                    prv_len_reg    <= len_mem[ia_m1];
                end
                CMD_MERGE_NEXT:
                begin
                    len_mem[ia] <= cur_len_reg + nxt_len_reg;
                    cur_len_reg <= cur_len_reg + nxt_len_reg;
                    sh_reg      <= idx_reg + CW'(1);
                    shift_done_reg <= 1'b0;
                end
                CMD_MERGE_PREV:
                begin
                    len_mem[ia_m1] <= prv_len_reg + cur_len_reg;
                    cur_start_reg  <= prv_start_reg;
                    cur_len_reg    <= prv_len_reg + cur_len_reg;
                    idx_reg        <= idx_reg - CW'(1);
                    sh_reg         <= idx_reg;
                    shift_done_reg <= 1'b0;
                end
                CMD_READ:
                begin
                    sh_reg <= count_reg;
                    shift_done_reg <= 1'b0;
                end
                CMD_RESULT:
                begin
                    out_start_reg <= cur_start_reg;
                    out_len_reg   <= cur_len_reg;
                    out_free_reg  <= cur_free_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/ffra_ctrl.sv =====
module ffra_ctrl
    import ffra_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        load_req,
    output cmd_t        cmd,
    input  dp_status_t  dps,
    input  logic [1:0]  op_held,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  out_status,
    output logic        out_zero
);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_CHECK, S_SCAN, S_DECIDE, S_SPLIT_SHIFT, S_SPLIT,
        S_MERGE_N, S_SHIFT_N, S_MERGE_P, S_SHIFT_P, S_DONE
    } state_t;

    state_t      state_reg, state_next;
    logic [1:0]  st_reg, st_next;
    logic        zero_reg, zero_next;
    logic        ov_reg, ov_next;
    logic [1:0]  out_st_reg, out_st_next;
    logic        out_zero_reg, out_zero_next;

    assign in_ready   = (state_reg == S_IDLE);
    assign load_req   = in_valid && in_ready;
    assign out_valid  = ov_reg;
    assign out_status = out_st_reg;
    assign out_zero   = out_zero_reg;

    // Next state and command
    always_comb
    begin
        state_next    = state_reg;
        st_next       = st_reg;
        zero_next     = zero_reg;
        ov_next       = ov_reg && !out_ready;
        out_st_next   = out_st_reg;
        out_zero_next = out_zero_reg;
        cmd           = CMD_NONE;
        unique case (state_reg)
            S_INIT:
            begin
                cmd = CMD_INIT;
                state_next = S_IDLE;
            end
            S_IDLE:
                if (load_req)
                begin
                    cmd = CMD_SCAN_START;
                    state_next = S_CHECK;
                end
            S_CHECK:
            begin
                if (op_held == OP_ALLOC && dps.req_zero ||
                    op_held != OP_ALLOC && (op_held == OP_UNUSED || dps.index_bad))
                begin
                    st_next = ST_BAD; zero_next = 1'b1; state_next = S_DONE;
                end
                else
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (dps.scan_end)
                begin
                    st_next = (op_held == OP_ALLOC) ? ST_NOFIT : ST_BAD;
                    zero_next = 1'b1; state_next = S_DONE;
                end
                else if (dps.scan_hit)
                    state_next = S_DECIDE;
                else
                    cmd = CMD_SCAN_STEP;
            end
            S_DECIDE:
            begin
                st_next = ST_OK; zero_next = 1'b0;
                if (op_held == OP_FIND)
                    state_next = S_DONE;
                else if (op_held == OP_ALLOC)
                begin
                    if (!dps.split_needed)
                    begin
                        cmd = CMD_ALLOC_EXACT; state_next = S_DONE;
                    end
                    else if (dps.table_full)
                    begin
                        st_next = ST_FULL; zero_next = 1'b1; state_next = S_DONE;
                    end
                    else
                    begin
                        cmd = CMD_READ; state_next = S_SPLIT_SHIFT;
                    end
                end
                else
                begin
                    cmd = CMD_FREE_MARK; state_next = S_MERGE_N;
                end
            end
            S_SPLIT_SHIFT:
            begin
                cmd = CMD_SHIFT_UP;
                if (dps.shift_done)
                begin
                    cmd = CMD_ALLOC_SPLIT; state_next = S_DONE;
                end
            end
            S_MERGE_N:
                if (dps.next_free)
                begin
                    cmd = CMD_MERGE_NEXT; state_next = S_SHIFT_N;
                end
                else
                    state_next = S_MERGE_P;
            S_SHIFT_N:
            begin
                cmd = CMD_SHIFT_DOWN;
                if (dps.shift_done)
                begin
                    cmd = CMD_NONE; state_next = S_MERGE_P;
                end
            end
            S_MERGE_P:
                if (dps.prev_free)
                begin
                    cmd = CMD_MERGE_PREV; state_next = S_SHIFT_P;
                end
                else
                    state_next = S_DONE;
            S_SHIFT_P:
            begin
                cmd = CMD_SHIFT_DOWN;
                if (dps.shift_done)
                begin
                    cmd = CMD_NONE; state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // wait here while the output register still holds an unsent result
                if (!ov_reg || out_ready)
                begin
                    cmd           = CMD_RESULT;
                    ov_next       = 1'b1;
                    out_st_next   = st_reg;
                    out_zero_next = zero_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            st_reg       <= ST_OK;
            zero_reg     <= 1'b0;
            ov_reg       <= 1'b0;
            out_st_reg   <= ST_OK;
            out_zero_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            st_reg       <= st_next;
            zero_reg     <= zero_next;
            ov_reg       <= ov_next;
            out_st_reg   <= out_st_next;
            out_zero_reg <= out_zero_next;
        end
    end

endmodule

// ===== rtl/core/first_fit_range_allocator_top.sv =====
// Channel  | Direction | Handshake              | Payload
// s_axis   | in        | s_axis_tvalid/tready   | tdata: request_blocks, block_index; tuser: op
// m_axis   | out       | m_axis_tvalid/tready   | tdata: range_start, range_length, range_free;
//          |           |                        | tuser: status
// cfg      | in        | cfg_valid/cfg_ready    | cfg_data: page_blocks
// One request at a time: the request is checked, then the table is scanned entry by entry
// (a bad size, index or op skips the scan; a miss scans every entry). A split first moves
// later entries up to open a slot; a free marks the entry, then merges with a free next and
// then a free previous range, each merge moving later entries down. Scan and shifts set the worst case.
// rst_n is asynchronous; the init state after reset sets one free range covering 1024 blocks.
// A result waiting on m_axis lets the next request in but holds back its result.
module first_fit_range_allocator_top
    import ffra_pkg::*;
#(
    parameter int MAX_RANGES      = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // request_blocks[10:0], block_index[20:11], zero fill
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // range_start[9:0], range_length[20:10], range_free[21]
    output logic [1:0]  m_axis_tuser,   // status[1:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data
);

    cmd_t        cmd;
    dp_status_t  dps;
    logic        load_req;
    logic        zero;
    logic [9:0]  r_start;
    logic [10:0] r_len;
    logic        r_free;
    logic [1:0]  op_held_reg;

    assign cfg_ready = 1'b1;

    // Held op for the controller
    always_ff @(posedge clk)
    begin
        if (load_req)
            op_held_reg <= s_axis_tuser;
    end

    ffra_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .load_req   (load_req),
        .cmd        (cmd),
        .dps        (dps),
        .op_held    (op_held_reg),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (m_axis_tuser),
        .out_zero   (zero)
    );

    ffra_datapath #(
        .MAX_RANGES      (MAX_RANGES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .load_req   (load_req),
        .in_op      (s_axis_tuser),
        .in_req     (s_axis_tdata[10:0]),
        .in_blk     (s_axis_tdata[20:11]),
        .cfg_we     (cfg_valid),
        .cfg_data   (cfg_data),
        .status     (dps),
        .res_start  (r_start),
        .res_length (r_len),
        .res_free   (r_free)
    );

    // Error results carry zero fields
    assign m_axis_tdata = zero ? 24'd0 : {2'b00, r_free, r_len, r_start};

endmodule

// ===== dv/tb_first_fit_range_allocator_top.sv =====
`timescale 1ns / 100ps

module tb_first_fit_range_allocator_top;
    import ffra_pkg::*;

    localparam int NUM_RANGES = 64;
    localparam int PAGE_MAX   = 1024;
    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  start;
        logic [10:0] length;
        logic        free;
    } alloc_result_t;

    // Range table model and queue of pending results
    class range_scoreboard;
        int unsigned   page;
        int unsigned   starts[NUM_RANGES];
        int unsigned   lengths[NUM_RANGES];
        bit            frees[NUM_RANGES];
        int unsigned   count;
        alloc_result_t pending[$];
        int            errors;

        function void set_page(int unsigned v);
            page = (v == 0) ? 1 : (v > PAGE_MAX ? PAGE_MAX : v);
            starts[0] = 0;
            lengths[0] = page;
            frees[0] = 1;
            count = 1;
        endfunction

        function void drop(int unsigned pos);
            for (int unsigned k = pos; k + 1 < count; k++)
            begin
                starts[k] = starts[k + 1];
                lengths[k] = lengths[k + 1];
                frees[k] = frees[k + 1];
            end
            count--;
        endfunction

        function alloc_result_t compute(logic [1:0] op, int unsigned req, int unsigned blk);
            alloc_result_t r;
            int unsigned   i;
            r = '0;
            r.status = ST_BAD;
            if (op == OP_ALLOC)
            begin
                if (req == 0) return r;
                for (i = 0; i < count; i++)
                    if (frees[i] && lengths[i] >= req) break;
                r.status = ST_NOFIT;
                if (i >= count) return r;
                if (lengths[i] > req)
                begin
                    r.status = ST_FULL;
                    if (count >= NUM_RANGES) return r;
                    for (int unsigned k = count; k > i + 1; k--)
                    begin
                        starts[k] = starts[k - 1];
                        lengths[k] = lengths[k - 1];
                        frees[k] = frees[k - 1];
                    end
                    starts[i + 1] = starts[i] + req;
                    lengths[i + 1] = lengths[i] - req;
                    frees[i + 1] = 1;
                    count++;
                    lengths[i] = req;
                end
                frees[i] = 0;
                r.status = ST_OK;
                r.start = starts[i];
                r.length = lengths[i];
                r.free = 0;
                return r;
            end
            if (op != OP_FREE && op != OP_FIND) return r;
            if (blk >= page) return r;
            for (i = 0; i < count; i++)
                if (blk >= starts[i] && blk < starts[i] + lengths[i]) break;
            if (i >= count) return r;
            if (op == OP_FREE)
            begin
                frees[i] = 1;
                if (i + 1 < count && frees[i + 1])
                begin
                    lengths[i] += lengths[i + 1];
                    drop(i + 1);
                end
                if (i > 0 && frees[i - 1])
                begin
                    lengths[i - 1] += lengths[i];
                    drop(i);
                    i--;
                end
            end
            r.status = ST_OK;
            r.start = starts[i];
            r.length = lengths[i];
            r.free = frees[i];
            return r;
        endfunction

        function void note_request(logic [1:0] op, int unsigned req, int unsigned blk);
            pending = {pending, compute(op, req, blk)};
        endfunction

        task report_mismatch(string what, longint want, longint got);
            errors++;
            $display("MISMATCH %s: expected %0d got %0d at %0t", what, want, got, $realtime);
        endtask

        task check_result(alloc_result_t got);
            alloc_result_t want;
            if (pending.size() == 0)
            begin
                report_mismatch("unexpected result", 0, got);
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status) report_mismatch("status", want.status, got.status);
            if (got.start !== want.start) report_mismatch("range_start", want.start, got.start);
            if (got.length !== want.length)
                report_mismatch("range_length", want.length, got.length);
            if (got.free !== want.free) report_mismatch("range_free", want.free, got.free);
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [10:0] cfg_data;

    range_scoreboard sb;
    bit  quiet_mode;
    bit  sink_gaps;

    first_fit_range_allocator_top DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Result sink with random stalls
    initial
    begin
        m_axis_tready = 0;
        forever
        begin
            @(negedge clk);
            if (sink_gaps && !quiet_mode && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 0;
                repeat ($urandom_range(1, 17)) @(negedge clk);
            end
            m_axis_tready <= 1;
        end
    end

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result({m_axis_tuser, m_axis_tdata[9:0], m_axis_tdata[20:10],
                             m_axis_tdata[21]});

    // Leaves tvalid high afterwards; the next call reuses it, a drain drops it
    task automatic send_request(logic [1:0] op, int unsigned req, int unsigned blk);
        if (!quiet_mode && $urandom_range(0, 7) == 0)
        begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= op;
        s_axis_tdata <= {3'b0, blk[9:0], req[10:0]};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sb.note_request(op, req, blk);
        @(negedge clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (3 * NUM_RANGES + 10) @(negedge clk);
    endtask

    task automatic write_page(int unsigned v);
        drain_results();
        cfg_valid <= 1;
        cfg_data <= v[10:0];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_page(v);
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    // Mostly alloc/free into live ranges, some noise
    task automatic random_phase(int n, int unsigned maxreq);
        int unsigned pick;
        int unsigned req;
        int unsigned blk;
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(0, 99);
            req = $urandom_range(1, maxreq);
            blk = $urandom_range(0, sb.page - 1);
            if (pick < 3) send_request(OP_ALLOC, $urandom_range(0, 2047), $urandom);
            else if (pick < 5) send_request(OP_SPARE, $urandom, $urandom);
            else if (pick < 8) send_request(2'($urandom_range(1, 2)), 0, $urandom_range(0, 1023));
            else if (pick < 50) send_request(OP_ALLOC, req, $urandom);
            else if (pick < 85) send_request(OP_FREE, $urandom, blk);
            else send_request(OP_FIND, $urandom, blk);
        end
    endtask

    initial
    begin
        sb = new();
        sb.set_page(1024);
        sb.errors = 0;
        quiet_mode = 0;
        sink_gaps = 1;
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_ALLOC;
        cfg_valid = 0;
        cfg_data = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // Directed: zero size, oversize, exact fit, free merges, bad index, spare op
        send_request(OP_ALLOC, 0, 0);
        send_request(OP_ALLOC, 1025, 0);
        send_request(OP_ALLOC, 2047, 1023);
        send_request(OP_FIND, 0, 1023);
        send_request(OP_ALLOC, 1, 0);
        send_request(OP_ALLOC, 10, 0);
        send_request(OP_ALLOC, 5, 0);
        send_request(OP_FREE, 0, 5);
        send_request(OP_FREE, 0, 5);
        send_request(OP_FREE, 0, 0);
        send_request(OP_FREE, 0, 1023);
        send_request(OP_SPARE, 2047, 1023);
        send_request(OP_ALLOC, 1024, 0);
        send_request(OP_FIND, 0, 500);
        write_page(0);
        send_request(OP_FIND, 0, 1);
        send_request(OP_ALLOC, 1, 0);
        send_request(OP_FREE, 0, 0);
        write_page(2047);
        send_request(OP_FIND, 0, 1023);
        write_page(100);
        send_request(OP_FREE, 0, 100);
        // Fill the table with single-block ranges to hit table full
        for (int k = 0; k < 66; k++) send_request(OP_ALLOC, 1, 0);
        write_page(70);
        for (int k = 0; k < 63; k++) send_request(OP_ALLOC, 1, 0);
        send_request(OP_ALLOC, 2, 0);
        send_request(OP_ALLOC, 7, 0);
        send_request(OP_FREE, 0, 3);
        drain_results();

        write_page(1024);
        random_phase(500, 64);
        write_page(200);
        random_phase(400, 16);
        write_page(1);
        random_phase(80, 2);
        write_page(1000);
        random_phase(300, 1024);
        write_page(1024);
        quiet_mode = 1;
        sink_gaps = 0;
        random_phase(300, 40);

        drain_results();
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #(20_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== first_fit_range_allocator_top.f =====
rtl/core/ffra_pkg.sv
rtl/core/ffra_datapath.sv
rtl/core/ffra_ctrl.sv
rtl/core/first_fit_range_allocator_top.sv
dv/tb_first_fit_range_allocator_top.sv
